// ===== hw/rtl/quantized_dot_product_dequant_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quantized dot product block
// Concurrent assertion wrappers, clocked on i_clk and held off during reset.
// They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_DOT_PRODUCT_DEQUANT_DEFINES_SVH
`define QUANTIZED_DOT_PRODUCT_DEQUANT_DEFINES_SVH

`ifndef SYNTH
// Property that must hold in the same cycle.
`define QDPD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
// Consequence that must hold in the cycle after the antecedent.
`define QDPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QDPD_ASSERT(label, cond, msg)
`define QDPD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/qdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdpd_pkg
// Widths, limits and register indexes of the quantized dot product block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdpd_pkg;

    // Accumulator size and the deepest dot product that is counted exactly.
    localparam int ACC_BITS  = 48;
    localparam int MAX_DEPTH = 65536;

    localparam int VAL_W    = 16;
    localparam int U8_W     = 8;
    localparam int PAIR_W   = 32;
    localparam int SUM_BITS = 24;
    localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
    localparam int COEF_W   = 32;
    localparam int OUT_W    = 64;
    localparam int SHIFT    = 8;

    // The coefficient times accumulator product is split in two halves.
    localparam int ACC_LO   = ACC_BITS / 2;
    localparam int ACC_HI   = ACC_BITS - ACC_LO;
    localparam int PP_LO_W  = COEF_W + ACC_LO + 1;
    localparam int PP_HI_W  = COEF_W + ACC_HI;
    localparam int PS_W     = COEF_W + SUM_BITS + 1;
    localparam int PC_W     = COEF_W + CNT_W + 1;
    localparam int SUM_W    = COEF_W + ACC_BITS + 2;
    localparam int SH_W     = SUM_W - SHIFT;
    localparam int RES_W    = ((SH_W > OUT_W) ? SH_W : OUT_W) + 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 2 * VAL_W + OUT_W;
    localparam int M_TDATA_W = OUT_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DOT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SUM_M = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SUM_V = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST = 3'd4;

    localparam logic MODE_S16 = 1'b0;
    localparam logic MODE_U8  = 1'b1;

endpackage

// ===== hw/rtl/quantized_dot_product_dequant.sv =====
// ----------------------------------------------------------------------------
// quantized_dot_product_dequant
// Streaming dot product of quantized value pairs with a dequantizing combine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes one pair of quantized values per clock when not stalled
// and produces one dequantized Q47.16 element for every run of pairs that
// ends with tlast. In mode 0 the values are signed 16-bit; in mode 1 only
// their low 8 bits count, unsigned, and the offset terms coef_sum_m*sum_m +
// coef_sum_v*sum_v + coef_const*count are added to coef_dot*dot. prior_value
// of the last pair is added to the Q.24 total after it is truncated to Q.16,
// and the result saturates to 64 bits. The overflow flag (tuser) reports any
// saturation of the accumulator, the sums, the pair count or the result in that
// run. Throughput is one pair per cycle while the skid buffer is not full:
// the pair product is registered, the accumulators close their loop in a
// single 48-bit add, and the combine runs down its own pipeline (split 32x24
// partial products, two adder stages, shift and saturate), so the next run
// starts on the cycle after a last pair. An output register plus a one-entry
// skid buffer hold finished results; the input only stalls when both are full,
// so a result waiting on the master side does not block accumulation.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no pair or result is in flight in the pipeline. A run
// left open keeps its partial sums and continues under the new settings.
`include "quantized_dot_product_dequant_defines.svh"

module quantized_dot_product_dequant (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave side. tdata: m_value [15:0], v_value [31:16], prior_value [95:32].
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [qdpd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_pair
    // Master side. tdata: result_value [63:0].
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [qdpd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,   // overflow
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qdpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qdpd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import qdpd_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam logic [CNT_W-1:0]           CNT_MAX = CNT_W'(MAX_DEPTH);
    localparam logic signed [OUT_W-1:0]    OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]    OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                     r_mode;
    logic signed [COEF_W-1:0] r_coef_dot;
    logic signed [COEF_W-1:0] r_coef_sum_m;
    logic signed [COEF_W-1:0] r_coef_sum_v;
    logic signed [COEF_W-1:0] r_coef_const;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_S16;
            r_coef_dot   <= '0;
            r_coef_sum_m <= '0;
            r_coef_sum_v <= '0;
            r_coef_const <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:       r_mode       <= i_cfg_data[0];
                REG_COEF_DOT:   r_coef_dot   <= i_cfg_data;
                REG_COEF_SUM_M: r_coef_sum_m <= i_cfg_data;
                REG_COEF_SUM_V: r_coef_sum_v <= i_cfg_data;
                REG_COEF_CONST: r_coef_const <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: the whole pipe advances unless the skid is full.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_skid_valid;
    logic w_en;

    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic                     r_s0_valid;
    logic [VAL_W-1:0]         r_s0_m;
    logic [VAL_W-1:0]         r_s0_v;
    logic signed [OUT_W-1:0]  r_s0_prior;
    logic                     r_s0_last;

    // ------------------------------------------------------------------
    // Stage 1: pair product and unsigned values for the sums
    // ------------------------------------------------------------------
    logic                      r_s1_valid;
    logic signed [PAIR_W-1:0]  r_s1_prod;
    logic [U8_W-1:0]           r_s1_um;
    logic [U8_W-1:0]           r_s1_uv;
    logic signed [OUT_W-1:0]   r_s1_prior;
    logic                      r_s1_last;
    logic                      r_s1_mode;

    logic signed [VAL_W:0]     w_m_ext;
    logic signed [VAL_W:0]     w_v_ext;
    logic signed [2*VAL_W+1:0] w_prod_full;

    // In mode 1 the low byte is taken as unsigned; otherwise sign-extend.
    always_comb begin
        if (r_mode == MODE_U8) begin
            w_m_ext = signed'((VAL_W+1)'(r_s0_m[U8_W-1:0]));
            w_v_ext = signed'((VAL_W+1)'(r_s0_v[U8_W-1:0]));
        end else begin
            w_m_ext = signed'({r_s0_m[VAL_W-1], r_s0_m});
            w_v_ext = signed'({r_s0_v[VAL_W-1], r_s0_v});
        end
    end

    // The magnitude never exceeds 2^30, so 32 bits hold the product.
    assign w_prod_full = w_m_ext * w_v_ext;

    // ------------------------------------------------------------------
    // Stage 2: accumulation state and capture of a finished run
    // ------------------------------------------------------------------
    logic signed [ACC_BITS-1:0] r_dot_acc;
    logic [SUM_BITS-1:0]        r_sum_first;
    logic [SUM_BITS-1:0]        r_sum_second;
    logic [CNT_W-1:0]           r_pair_count;
    logic                       r_sat_seen;

    logic signed [ACC_BITS:0]   w_acc_sum;
    logic                       w_acc_ovf;
    logic [SUM_BITS:0]          w_sf_sum;
    logic [SUM_BITS:0]          w_ss_sum;
    logic                       w_sum_ovf;
    logic                       w_cnt_full;
    logic signed [ACC_BITS-1:0] n_dot_acc;
    logic [SUM_BITS-1:0]        n_sum_first;
    logic [SUM_BITS-1:0]        n_sum_second;
    logic [CNT_W-1:0]           n_pair_count;
    logic                       n_sat_seen;

    always_comb begin
        w_acc_sum = (ACC_BITS+1)'(r_dot_acc) + (ACC_BITS+1)'(r_s1_prod);
        w_acc_ovf = w_acc_sum[ACC_BITS] != w_acc_sum[ACC_BITS-1];
        if (w_acc_ovf) begin
            n_dot_acc = w_acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            n_dot_acc = w_acc_sum[ACC_BITS-1:0];
        end

        w_sf_sum = (SUM_BITS+1)'(r_sum_first) + (SUM_BITS+1)'(r_s1_um);
        w_ss_sum = (SUM_BITS+1)'(r_sum_second) + (SUM_BITS+1)'(r_s1_uv);
        if (r_s1_mode == MODE_U8) begin
            n_sum_first  = w_sf_sum[SUM_BITS] ? '1 : w_sf_sum[SUM_BITS-1:0];
            n_sum_second = w_ss_sum[SUM_BITS] ? '1 : w_ss_sum[SUM_BITS-1:0];
            w_sum_ovf    = w_sf_sum[SUM_BITS] | w_ss_sum[SUM_BITS];
        end else begin
            n_sum_first  = r_sum_first;
            n_sum_second = r_sum_second;
            w_sum_ovf    = 1'b0;
        end

        // Past the deepest run the count holds; the pair still accumulates.
        w_cnt_full   = r_pair_count >= CNT_MAX;
        n_pair_count = w_cnt_full ? CNT_MAX : r_pair_count + CNT_W'(1);

        n_sat_seen = r_sat_seen | w_acc_ovf | w_sum_ovf | w_cnt_full;
    end

    logic                       r_s2_valid;
    logic signed [ACC_BITS-1:0] r_s2_dot;
    logic [SUM_BITS-1:0]        r_s2_sf;
    logic [SUM_BITS-1:0]        r_s2_ss;
    logic [CNT_W-1:0]           r_s2_cnt;
    logic                       r_s2_sat;
    logic                       r_s2_mode;
    logic signed [OUT_W-1:0]    r_s2_prior;

    // ------------------------------------------------------------------
    // Stage 3: partial products of the combine
    // ------------------------------------------------------------------
    logic signed [ACC_HI-1:0]   w_dot_hi;
    logic signed [ACC_LO:0]     w_dot_lo;
    logic signed [SUM_BITS:0]   w_sf_s;
    logic signed [SUM_BITS:0]   w_ss_s;
    logic signed [CNT_W:0]      w_cnt_s;
    logic signed [PP_HI_W-1:0]  n_pp_hi;
    logic signed [PP_LO_W-1:0]  n_pp_lo;
    logic signed [PS_W-1:0]     n_ps_m;
    logic signed [PS_W-1:0]     n_ps_v;
    logic signed [PC_W-1:0]     n_pc;

    assign w_dot_hi = r_s2_dot[ACC_BITS-1:ACC_LO];
    assign w_dot_lo = signed'({1'b0, r_s2_dot[ACC_LO-1:0]});
    assign w_sf_s   = signed'({1'b0, r_s2_sf});
    assign w_ss_s   = signed'({1'b0, r_s2_ss});
    assign w_cnt_s  = signed'({1'b0, r_s2_cnt});

    assign n_pp_hi = r_coef_dot * w_dot_hi;
    assign n_pp_lo = r_coef_dot * w_dot_lo;
    assign n_ps_m  = r_coef_sum_m * w_sf_s;
    assign n_ps_v  = r_coef_sum_v * w_ss_s;
    assign n_pc    = r_coef_const * w_cnt_s;

    logic                      r_s3_valid;
    logic signed [PP_HI_W-1:0] r_s3_pp_hi;
    logic signed [PP_LO_W-1:0] r_s3_pp_lo;
    logic signed [PS_W-1:0]    r_s3_ps_m;
    logic signed [PS_W-1:0]    r_s3_ps_v;
    logic signed [PC_W-1:0]    r_s3_pc;
    logic                      r_s3_sat;
    logic                      r_s3_mode;
    logic signed [OUT_W-1:0]   r_s3_prior;

    // ------------------------------------------------------------------
    // Stage 4: dot term and offset term, exact in Q.24
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] n_dterm;
    logic signed [SUM_W-1:0] n_oterm;

    always_comb begin
        n_dterm = (SUM_W'(r_s3_pp_hi) <<< ACC_LO) + SUM_W'(r_s3_pp_lo);
        if (r_s3_mode == MODE_U8) begin
            n_oterm = SUM_W'(r_s3_ps_m) + SUM_W'(r_s3_ps_v) + SUM_W'(r_s3_pc);
        end else begin
            n_oterm = '0;
        end
    end

    logic                    r_s4_valid;
    logic signed [SUM_W-1:0] r_s4_dterm;
    logic signed [SUM_W-1:0] r_s4_oterm;
    logic                    r_s4_sat;
    logic signed [OUT_W-1:0] r_s4_prior;

    // ------------------------------------------------------------------
    // Stage 5: total in Q.24
    // ------------------------------------------------------------------
    logic                    r_s5_valid;
    logic signed [SUM_W-1:0] r_s5_total;
    logic                    r_s5_sat;
    logic signed [OUT_W-1:0] r_s5_prior;

    // ------------------------------------------------------------------
    // Final combine: truncate to Q.16, add prior, saturate to 64 bits.
    // ------------------------------------------------------------------
    logic signed [SH_W-1:0]    w_shifted;
    logic signed [RES_W-1:0]   w_res_sum;
    logic                      w_res_ovf;
    logic signed [OUT_W-1:0]   n_result;
    logic                      n_overflow;
    logic [RES_W-OUT_W:0]      w_res_top;

    always_comb begin
        w_shifted  = r_s5_total[SUM_W-1:SHIFT];
        w_res_sum  = RES_W'(w_shifted) + RES_W'(r_s5_prior);
        w_res_top  = w_res_sum[RES_W-1:OUT_W-1];
        w_res_ovf  = (w_res_top != '0) && (w_res_top != '1);
        if (w_res_ovf) begin
            n_result = w_res_sum[RES_W-1] ? OUT_MIN : OUT_MAX;
        end else begin
            n_result = w_res_sum[OUT_W-1:0];
        end
        n_overflow = r_s5_sat | w_res_ovf;
    end

    // ------------------------------------------------------------------
    // Pipeline control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_s4_valid   <= 1'b0;
            r_s5_valid   <= 1'b0;
            r_dot_acc    <= '0;
            r_sum_first  <= '0;
            r_sum_second <= '0;
            r_pair_count <= '0;
            r_sat_seen   <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= s_axis_tvalid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid && r_s1_last;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    // The run is handed to the combine; start the next one clean.
                    r_dot_acc    <= '0;
                    r_sum_first  <= '0;
                    r_sum_second <= '0;
                    r_pair_count <= '0;
                    r_sat_seen   <= 1'b0;
                end else begin
                    r_dot_acc    <= n_dot_acc;
                    r_sum_first  <= n_sum_first;
                    r_sum_second <= n_sum_second;
                    r_pair_count <= n_pair_count;
                    r_sat_seen   <= n_sat_seen;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (s_axis_tvalid) begin
                r_s0_m     <= s_axis_tdata[VAL_W-1:0];
                r_s0_v     <= s_axis_tdata[2*VAL_W-1:VAL_W];
                r_s0_prior <= s_axis_tdata[S_TDATA_W-1:2*VAL_W];
                r_s0_last  <= s_axis_tlast;
            end

            r_s1_prod  <= w_prod_full[PAIR_W-1:0];
            r_s1_um    <= r_s0_m[U8_W-1:0];
            r_s1_uv    <= r_s0_v[U8_W-1:0];
            r_s1_prior <= r_s0_prior;
            r_s1_last  <= r_s0_last;
            r_s1_mode  <= r_mode;

            if (r_s1_valid && r_s1_last) begin
                r_s2_dot   <= n_dot_acc;
                r_s2_sf    <= n_sum_first;
                r_s2_ss    <= n_sum_second;
                r_s2_cnt   <= n_pair_count;
                r_s2_sat   <= n_sat_seen;
                r_s2_mode  <= r_s1_mode;
                r_s2_prior <= r_s1_prior;
            end

            r_s3_pp_hi <= n_pp_hi;
            r_s3_pp_lo <= n_pp_lo;
            r_s3_ps_m  <= n_ps_m;
            r_s3_ps_v  <= n_ps_v;
            r_s3_pc    <= n_pc;
            r_s3_sat   <= r_s2_sat;
            r_s3_mode  <= r_s2_mode;
            r_s3_prior <= r_s2_prior;

            r_s4_dterm <= n_dterm;
            r_s4_oterm <= n_oterm;
            r_s4_sat   <= r_s3_sat;
            r_s4_prior <= r_s3_prior;

            r_s5_total <= r_s4_dterm + r_s4_oterm;
            r_s5_sat   <= r_s4_sat;
            r_s5_prior <= r_s4_prior;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid buffer
    // ------------------------------------------------------------------
    logic                    w_push;
    logic                    w_pop;
    logic signed [OUT_W-1:0] r_out_result;
    logic                    r_out_overflow;
    logic signed [OUT_W-1:0] r_skid_result;
    logic                    r_skid_overflow;

    assign w_push = w_en && r_s5_valid;
    assign w_pop  = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_result   <= r_skid_result;
                r_out_overflow <= r_skid_overflow;
            end
        end else if (w_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_result   <= n_result;
                r_skid_overflow <= n_overflow;
            end else begin
                r_out_result   <= n_result;
                r_out_overflow <= n_overflow;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_result;
    assign m_axis_tuser  = r_out_overflow;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `QDPD_ASSERT(a_skid_behind_out, !r_skid_valid || r_out_valid,
        "skid buffer holds a result while the output register is empty")
    `QDPD_ASSERT(a_count_bound, r_pair_count <= CNT_MAX,
        "pair count went past its limit")
    `QDPD_ASSERT_NEXT(a_clear_after_last, w_en && r_s1_valid && r_s1_last,
        (r_pair_count == '0) && (r_dot_acc == '0) && !r_sat_seen,
        "accumulation state not cleared after a last pair")
    `QDPD_ASSERT_NEXT(a_hold_on_stall, !w_en,
        $stable(r_dot_acc) && $stable(r_pair_count) && $stable(r_s5_valid),
        "pipeline moved while stalled")

endmodule

// ===== dv/quantized_dot_product_dequant_test.sv =====
// ----------------------------------------------------------------------------
// quantized_dot_product_dequant_test
// Self-checking bench for the streaming quantized dot product block. Pairs
// and coefficient settings are driven through the stream and configuration
// channels. A tracker class mirrors the accumulation and the dequantizing
// combine at full precision and checks every element that leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantized_dot_product_dequant_test;

    import qdpd_pkg::*;

    // Saturation bounds of the running state.
    localparam longint ACC_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam int     SUM_MAX = (1 << SUM_BITS) - 1;

    // Cycles allowed for the combine pipeline to empty before a register write
    // and at the end of the run.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT    = 4000;
    localparam int RANDOM_PAIRS  = 1000;

    localparam logic [31:0] COEF_ONE = 32'h0100_0000;   // 1.0 in Q8.24

    typedef struct {
        logic signed [15:0] m_value;
        logic signed [15:0] v_value;
        logic signed [63:0] prior_value;
        logic               last_pair;
    } pair_t;

    typedef struct {
        logic [63:0] result_value;
        logic        overflow;
    } element_t;

    // ------------------------------------------------------------------------
    // Tracks the coefficient registers and the partial dot product, and holds
    // the elements the block still owes us, oldest first.
    // ------------------------------------------------------------------------
    class dot_product_tracker;
        logic               mode;
        logic signed [31:0] coef_dot;
        logic signed [31:0] coef_sum_m;
        logic signed [31:0] coef_sum_v;
        logic signed [31:0] coef_const;
        longint             dot_acc;
        int                 sum_first;
        int                 sum_second;
        int                 pair_count;
        bit                 sat_seen;
        element_t           owed_elements[$];
        int                 mismatches;
        int                 elements_checked;
        int                 elements_saturated;

        function new();
            mode       = MODE_S16;
            coef_dot   = '0;
            coef_sum_m = '0;
            coef_sum_v = '0;
            coef_const = '0;
            mismatches = 0;
            elements_checked   = 0;
            elements_saturated = 0;
            clear_run();
        endfunction

        function void clear_run();
            dot_acc    = 0;
            sum_first  = 0;
            sum_second = 0;
            pair_count = 0;
            sat_seen   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
            case (index)
                REG_MODE:       mode       = data[0];
                REG_COEF_DOT:   coef_dot   = data;
                REG_COEF_SUM_M: coef_sum_m = data;
                REG_COEF_SUM_V: coef_sum_v = data;
                REG_COEF_CONST: coef_const = data;
                default: ;
            endcase
        endfunction

        // Folds one accepted pair into the run; a last pair closes the run and
        // queues the element it produces.
        function void take_pair(pair_t p);
            longint              m;
            longint              v;
            longint              prod;
            logic signed [127:0] total;
            element_t            owed;

            if (mode == MODE_U8) begin
                m = p.m_value[7:0];
                v = p.v_value[7:0];
            end else begin
                m = p.m_value;
                v = p.v_value;
            end
            prod = m * v;

            if (prod > 0 && dot_acc > ACC_MAX - prod) begin
                dot_acc  = ACC_MAX;
                sat_seen = 1'b1;
            end else if (prod < 0 && dot_acc < ACC_MIN - prod) begin
                dot_acc  = ACC_MIN;
                sat_seen = 1'b1;
            end else begin
                dot_acc += prod;
            end

            // Value sums only run in the unsigned 8-bit mode.
            if (mode == MODE_U8) begin
                if (sum_first > SUM_MAX - m) begin
                    sum_first = SUM_MAX;
                    sat_seen  = 1'b1;
                end else begin
                    sum_first += int'(m);
                end
                if (sum_second > SUM_MAX - v) begin
                    sum_second = SUM_MAX;
                    sat_seen   = 1'b1;
                end else begin
                    sum_second += int'(v);
                end
            end

            // The count sticks at the depth limit, the pair is still used.
            if (pair_count >= MAX_DEPTH) begin
                pair_count = MAX_DEPTH;
                sat_seen   = 1'b1;
            end else begin
                pair_count++;
            end

            if (!p.last_pair)
                return;

            // Exact Q.24 total, floor to Q.16, add the prior element, saturate.
            total = coef_dot * dot_acc;
            if (mode == MODE_U8) begin
                total = total + coef_sum_m * sum_first;
                total = total + coef_sum_v * sum_second;
                total = total + coef_const * pair_count;
            end
            total = total >>> SHIFT;
            total = total + p.prior_value;

            owed.overflow = sat_seen;
            if (total[127:63] == '0 || total[127:63] == '1) begin
                owed.result_value = total[63:0];
            end else begin
                owed.overflow     = 1'b1;
                owed.result_value = total[127] ? 64'h8000_0000_0000_0000
                                               : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            owed_elements.push_back(owed);
            clear_run();
        endfunction

        function void check_element(logic [63:0] result_value, logic overflow);
            element_t owed;

            if (owed_elements.size() == 0) begin
                $error("element arrived while none was owed: result_value %h",
                       result_value);
                mismatches++;
                return;
            end
            owed = owed_elements.pop_front();
            elements_checked++;
            if (owed.overflow)
                elements_saturated++;
            if (result_value !== owed.result_value) begin
                $error("result_value: expected %h, actual %h",
                       owed.result_value, result_value);
                mismatches++;
            end
            if (overflow !== owed.overflow) begin
                $error("overflow: expected %b, actual %b", owed.overflow, overflow);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and bench state
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dot_product_tracker tracker;
    bit                 no_idling;       // suppresses gaps on both sides
    int                 pairs_sent;
    int                 settings_used;
    int                 hang_cycles;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    quantized_dot_product_dequant DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // m_value, v_value, prior_value
        .s_axis_tlast  (s_axis_tlast),   // last_pair
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // result_value
        .m_axis_tuser  (m_axis_tuser),   // overflow
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Result side: every transaction is checked against the oldest owed
    // element, then tready is redrawn for the next cycle. Handshake signals
    // read here still hold their values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_element(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= no_idling || ($urandom_range(99) >= 23);
    end

    // A run that stops moving on every channel for too long has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d elements still owed",
                   HANG_LIMIT, tracker.owed_elements.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Raises or keeps the write strobe; apply_setting drops it afterwards so that
    // back-to-back writes never lower and raise it in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(index, data);
    endtask

    task automatic apply_setting(input logic mode, input logic [31:0] cd,
                                 input logic [31:0] cm, input logic [31:0] cv,
                                 input logic [31:0] cc);
        write_reg(REG_MODE, {31'd0, mode});
        write_reg(REG_COEF_DOT, cd);
        write_reg(REG_COEF_SUM_M, cm);
        write_reg(REG_COEF_SUM_V, cv);
        write_reg(REG_COEF_CONST, cc);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sends one pair, with random gaps in front of it unless idling is off.
    // tvalid stays high after the transaction so pairs can follow back to back.
    task automatic push_pair(input logic [15:0] m, input logic [15:0] v,
                             input logic [63:0] prior, input logic last);
        pair_t p;

        p.m_value     = m;
        p.v_value     = v;
        p.prior_value = prior;
        p.last_pair   = last;
        while (!no_idling && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.prior_value, p.v_value, p.m_value};
        s_axis_tlast  <= p.last_pair;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_pair(p);
        pairs_sent++;
    endtask

    // Stops the stream, waits for every owed element, then lets the combine
    // pipeline empty so that a run left open is not disturbed by a write.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_elements.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One long run of identical pairs.
    task automatic long_run(input logic [15:0] m, input logic [15:0] v, input int count);
        for (int k = 1; k <= count; k++)
            push_pair(m, v, 64'd0, k == count);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h00FF;
            3:       return 16'hFFFF;
            4:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_prior();
        case ($urandom_range(9))
            0:       return 64'h8000_0000_0000_0000;
            1:       return 64'h7FFF_FFFF_FFFF_FFFF;
            2:       return 64'd0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return COEF_ONE;
            4:       return -COEF_ONE;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int random_start;
        int run_len;
        int phase_target;
        int phase_pairs;
        int pick;

        tracker       = new();
        no_idling     = 1'b0;
        pairs_sent    = 0;
        settings_used = 0;
        hang_cycles   = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_MODE;
        i_cfg_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: signed mode with unit scale. The sum coefficients are set to
        // extremes and coef_const to 1.0 to show that signed mode ignores them.
        apply_setting(MODE_S16, COEF_ONE, 32'h7FFF_FFFF, 32'h8000_0000, COEF_ONE);
        push_pair(16'h8000, 16'h8000, 64'd0, 1'b1);
        push_pair(16'h7FFF, 16'h8000, 64'h0000_0000_0001_0000, 1'b0);
        push_pair(16'h7FFF, 16'h7FFF, 64'h8000_0000_0000_0000, 1'b1);
        // Result saturation in both directions.
        push_pair(16'h8000, 16'h8000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        push_pair(16'h8000, 16'h7FFF, 64'h8000_0000_0000_0000, 1'b1);
        push_pair(16'h0000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // A run opened in signed mode and finished in unsigned mode.
        push_pair(16'd100, 16'hFFFD, 64'd0, 1'b0);
        push_pair(16'hFFF9, 16'h7FFF, 64'd0, 1'b0);
        finish_phase();
        apply_setting(MODE_U8, COEF_ONE, COEF_ONE, -COEF_ONE, 32'h0000_4000);
        push_pair(16'hA5FF, 16'h00FF, 64'd0, 1'b0);
        push_pair(16'h1280, 16'hFF01, 64'h0000_1234_5678_9ABC, 1'b1);
        finish_phase();
        // Unsigned mode with coefficient extremes.
        apply_setting(MODE_U8, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF);
        push_pair(16'hFFFF, 16'h0000, 64'd0, 1'b1);
        push_pair(16'h00FF, 16'hFF00, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_pair(16'h00FF, 16'h00FF, 64'h8000_0000_0000_0000, 1'b1);
        finish_phase();

        // Longer runs of extreme values, streamed without gaps, so that the
        // accumulator and the unsigned sums grow well past a few pairs.
        no_idling = 1'b1;
        apply_setting(MODE_S16, 32'h0000_0001, 32'd0, 32'd0, 32'd0);
        long_run(16'h8000, 16'h8000, 120);
        long_run(16'h8000, 16'h7FFF, 120);
        finish_phase();
        apply_setting(MODE_U8, 32'h0000_0100, COEF_ONE, -COEF_ONE, 32'hFFFF_FF00);
        long_run(16'h00FF, 16'hFFFF, 120);
        finish_phase();
        no_idling = 1'b0;

        // Random runs under a series of settings. Most runs are short, a few
        // long; a phase sometimes ends with its run still open so that the
        // next setting picks it up.
        random_start = pairs_sent;
        for (int phase = 0; pairs_sent - random_start < RANDOM_PAIRS; phase++) begin
            if (phase == 0)
                apply_setting(MODE_U8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF);
            else if (phase == 1)
                apply_setting(MODE_U8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000);
            else
                apply_setting(1'($urandom), pick_coef(), pick_coef(), pick_coef(),
                              pick_coef());
            no_idling    = (phase == 3);
            phase_target = $urandom_range(60, 200);
            phase_pairs  = 0;
            while (phase_pairs < phase_target) begin
                pick    = $urandom_range(99);
                run_len = (pick < 80) ? $urandom_range(1, 12) :
                          (pick < 95) ? $urandom_range(13, 64) : $urandom_range(65, 300);
                for (int k = 1; k <= run_len; k++)
                    push_pair(pick_value(), pick_value(), pick_prior(), k == run_len);
                phase_pairs += run_len;
            end
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 5))
                    push_pair(pick_value(), pick_value(), pick_prior(), 1'b0);
            end
            finish_phase();
        end
        // Close any run the last phase left open.
        push_pair(pick_value(), pick_value(), pick_prior(), 1'b1);
        finish_phase();

        $display("Streamed %0d pairs under %0d coefficient settings.",
                 pairs_sent, settings_used);
        $display("Checked %0d elements, %0d of them flagged as saturated.",
                 tracker.elements_checked, tracker.elements_saturated);
        if (tracker.mismatches == 0 && tracker.owed_elements.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
